/* rtl/core/pcis_pkg.sv */
// ----------------------------------------------------------------------------
// pcis_pkg
// Shared constants and types for the piecewise constant inverse CDF sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcis_pkg;

    // Fixed formats
    localparam int MAX_BINS      = 256;
    localparam int WEIGHT_BITS   = 16;
    localparam int FRACTION_BITS = 24;
    localparam int DENSITY_FRAC  = 16;

    localparam int CDF_W      = FRACTION_BITS + 1;          // Q1.F, holds 1.0
    localparam int CNT_W      = $clog2(MAX_BINS + 1);       // holds MAX_BINS
    localparam int IDX_W      = $clog2(MAX_BINS);
    localparam int RAM_DEPTH  = MAX_BINS + 1;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);
    localparam int DIV_CNT_W  = $clog2(FRACTION_BITS);
    localparam int PROD_W     = CDF_W + CNT_W;
    localparam int DENS_SHIFT = FRACTION_BITS - DENSITY_FRAC;

    localparam logic [CDF_W-1:0]         ONE_Q   = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [FRACTION_BITS-1:0] POS_MAX = {FRACTION_BITS{1'b1}};

    // Item opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_BUILT = 1'b1;

    // Divider request: floor(({rem_init, low_bits}) / divisor), rem_init < divisor
    typedef struct packed {
        logic                     start;
        logic [CDF_W-1:0]         rem_init;
        logic [CDF_W-1:0]         divisor;
        logic [FRACTION_BITS-1:0] low_bits;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic [FRACTION_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/piecewise_constant_inverse_cdf_sampler.sv */
// ----------------------------------------------------------------------------
// piecewise_constant_inverse_cdf_sampler
// Builds a Q1.24 CDF from loaded bin weights and draws samples from it.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ---------------------------------
// cfg       in         cfg_valid / cfg_ready  size_in_use
// req       in         req_valid / req_stall  op, weight, seed
// res       out        res_valid / res_stall  sample_position, density,
//                                             bin_index, status
//
// A load item stores its prefix sum and the block stays idle; the load that
// completes the table starts a build with one 24-step division per CDF entry
// in the shared divider (a saturated entry and the last entry are written as
// 1.0 without one). A sample item runs a binary search with one RAM read per
// probe, then two 24-step divisions (bin offset, then position) in the same
// divider; a zero-width bin or a saturated offset skips the first. A sample
// before the table is built skips the search and returns status NOT_BUILT.
// Reset puts size at 256 and discards the table; the CDF RAM itself is not
// cleared. One output register holds the result, so a stalled result does not
// block the next item until it too has a result. req stalls while cfg_valid is
// up, so a size write never lands in the same cycle as an item.
//
`timescale 1ns / 1ps
`default_nettype none

module piecewise_constant_inverse_cdf_sampler
    import pcis_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CNT_W-1:0]         size_in_use,
    // request items
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire logic                     op,
    input  wire logic [WEIGHT_BITS-1:0]   weight,
    input  wire logic [FRACTION_BITS-1:0] seed,
    // result items
    output logic                          res_valid,
    input  wire logic                     res_stall,
    output logic [FRACTION_BITS-1:0]      sample_position,
    output logic [CDF_W-1:0]              density,
    output logic [IDX_W-1:0]              bin_index,
    output logic                          status
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;   // take items, store prefix sums
    localparam logic [3:0] ST_BZERO = 4'd1;   // build: entry 0 = 0
    localparam logic [3:0] ST_BRD   = 4'd2;   // build: read prefix sum i
    localparam logic [3:0] ST_BCHK  = 4'd3;   // build: saturate or divide
    localparam logic [3:0] ST_BDIV  = 4'd4;   // build: wait for quotient
    localparam logic [3:0] ST_PROBE = 4'd5;   // search: issue midpoint read
    localparam logic [3:0] ST_CMP   = 4'd6;   // search: narrow interval
    localparam logic [3:0] ST_LORD  = 4'd7;   // capture cdf[i], read cdf[i+1]
    localparam logic [3:0] ST_HIRD  = 4'd8;   // bin width and raw offset
    localparam logic [3:0] ST_OFF   = 4'd9;   // density, start offset divide
    localparam logic [3:0] ST_ODIV  = 4'd10;  // wait offset quotient
    localparam logic [3:0] ST_POS   = 4'd11;  // start position divide by n
    localparam logic [3:0] ST_PDIV  = 4'd12;  // wait position quotient
    localparam logic [3:0] ST_EMIT  = 4'd13;  // hand result to output reg

    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         n_reg, n_next;          // bins in use, clamped
    logic [CNT_W-1:0]         lc_reg, lc_next;        // weights loaded so far
    logic                     built_reg, built_next;
    logic [CDF_W-1:0]         total_reg, total_next;  // running prefix sum
    logic [CNT_W-1:0]         bidx_reg, bidx_next;    // build entry index
    logic [FRACTION_BITS-1:0] seed_reg, seed_next;
    logic [IDX_W-1:0]         lo_reg, lo_next;
    logic [IDX_W-1:0]         hi_reg, hi_next;
    logic [IDX_W-1:0]         mid_reg, mid_next;
    logic [CDF_W-1:0]         lo_val_reg, lo_val_next;
    logic [CDF_W-1:0]         width_reg, width_next;
    logic [FRACTION_BITS-1:0] off_reg, off_next;
    logic [FRACTION_BITS-1:0] pos_reg, pos_next;
    logic [CDF_W-1:0]         dens_reg, dens_next;
    logic                     stat_reg, stat_next;

    logic                     res_valid_reg, res_valid_next;
    logic [FRACTION_BITS-1:0] res_pos_reg, res_pos_next;
    logic [CDF_W-1:0]         res_dens_reg, res_dens_next;
    logic [IDX_W-1:0]         res_idx_reg, res_idx_next;
    logic                     res_stat_reg, res_stat_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [CDF_W-1:0]         ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [CDF_W-1:0]         ram_rdata;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic                     req_accept;
    logic                     cfg_accept;
    logic [CNT_W-1:0]         size_clamped;
    logic [CNT_W-1:0]         n_m1;
    logic [CNT_W-1:0]         lc_eff;
    logic [CNT_W-1:0]         lc_new;
    logic [CDF_W-1:0]         sum_new;
    logic [IDX_W:0]           mid_sum;
    logic [IDX_W-1:0]         mid;
    logic [CDF_W-1:0]         seed_ext;
    logic                     total_zero;
    logic [CDF_W-1:0]         build_num;
    logic [CDF_W-1:0]         build_den;
    logic [CNT_W-1:0]         bidx_inc;
    logic [PROD_W-1:0]        dens_prod;
    logic [CDF_W-1:0]         raw_off;

    pcis_ram #(
        .DATA_W (CDF_W),
        .DEPTH  (RAM_DEPTH)
    ) u_cdf_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pcis_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready  = (state_reg == ST_IDLE);
    // a pending size write goes first
    assign req_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign req_accept = req_valid && !req_stall;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Size 0 acts as one bin, anything above the store acts as a full store
    assign size_clamped = (size_in_use == '0) ? CNT_W'(1) :
                          (size_in_use > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) :
                          size_in_use;

    assign n_m1 = n_reg - CNT_W'(1);

    // A load after a finished build starts a fresh sequence
    assign lc_eff  = (built_reg || (lc_reg >= n_reg)) ? '0 : lc_reg;
    assign lc_new  = lc_eff + CNT_W'(1);
    assign sum_new = ((lc_eff == '0) ? '0 : total_reg) + CDF_W'(weight);

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} + (IDX_W + 1)'(1);
    assign mid      = mid_sum[IDX_W:1];
    assign seed_ext = {1'b0, seed_reg};

    // All-zero weights give the linear CDF i/n
    assign total_zero = (total_reg == '0);
    assign build_num  = total_zero ? CDF_W'(bidx_reg) : ram_rdata;
    assign build_den  = total_zero ? CDF_W'(n_reg) : total_reg;
    assign bidx_inc   = bidx_reg + CNT_W'(1);

    assign dens_prod = PROD_W'(width_reg) * PROD_W'(n_reg);
    assign raw_off   = (seed_ext >= lo_val_reg) ? (seed_ext - lo_val_reg) : '0;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        lc_next        = lc_reg;
        built_next     = built_reg;
        total_next     = total_reg;
        bidx_next      = bidx_reg;
        seed_next      = seed_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        lo_val_next    = lo_val_reg;
        width_next     = width_reg;
        off_next       = off_reg;
        pos_next       = pos_reg;
        dens_next      = dens_reg;
        stat_next      = stat_reg;
        res_valid_next = res_valid_reg;
        res_pos_next   = res_pos_reg;
        res_dens_next  = res_dens_reg;
        res_idx_next   = res_idx_reg;
        res_stat_next  = res_stat_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;
        div_req        = '0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    seed_next = seed;
                    if (op == OP_LOAD)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = ADDR_W'(lc_new);
                        ram_wdata  = sum_new;
                        total_next = sum_new;
                        lc_next    = lc_new;
                        built_next = 1'b0;
                        if (lc_new >= n_reg)
                        begin
                            state_next = ST_BZERO;
                        end
                    end
                    else if (!built_reg)
                    begin
                        pos_next   = '0;
                        dens_next  = '0;
                        lo_next    = '0;
                        stat_next  = STATUS_NOT_BUILT;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = n_m1[IDX_W-1:0];
                        stat_next  = STATUS_OK;
                        state_next = ST_PROBE;
                    end
                end
            end

            ST_BZERO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = '0;
                bidx_next  = CNT_W'(1);
                state_next = ST_BRD;
            end

            ST_BRD:
            begin
                if (bidx_reg == n_reg)
                begin
                    // last entry is exactly 1.0
                    ram_we     = 1'b1;
                    ram_waddr  = ADDR_W'(bidx_reg);
                    ram_wdata  = ONE_Q;
                    built_next = 1'b1;
                    lc_next    = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_raddr  = ADDR_W'(bidx_reg);
                    state_next = ST_BCHK;
                end
            end

            ST_BCHK:
            begin
                if (build_num >= build_den)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = ADDR_W'(bidx_reg);
                    ram_wdata  = ONE_Q;
                    bidx_next  = bidx_inc;
                    state_next = ST_BRD;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = build_num;
                    div_req.divisor  = build_den;
                    div_req.low_bits = '0;
                    state_next       = ST_BDIV;
                end
            end

            ST_BDIV:
            begin
                if (div_rsp.done)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = ADDR_W'(bidx_reg);
                    ram_wdata  = {1'b0, div_rsp.quotient};
                    bidx_next  = bidx_inc;
                    state_next = ST_BRD;
                end
            end

            ST_PROBE:
            begin
                if (lo_reg == hi_reg)
                begin
                    ram_raddr  = ADDR_W'(lo_reg);
                    state_next = ST_LORD;
                end
                else
                begin
                    mid_next   = mid;
                    ram_raddr  = ADDR_W'(mid);
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                // largest index with cdf <= seed
                if (ram_rdata <= seed_ext)
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg - IDX_W'(1);
                end
                state_next = ST_PROBE;
            end

            ST_LORD:
            begin
                lo_val_next = ram_rdata;
                ram_raddr   = ADDR_W'(lo_reg) + ADDR_W'(1);
                state_next  = ST_HIRD;
            end

            ST_HIRD:
            begin
                width_next = (ram_rdata > lo_val_reg) ? (ram_rdata - lo_val_reg) : '0;
                off_next   = raw_off[FRACTION_BITS-1:0];
                state_next = ST_OFF;
            end

            ST_OFF:
            begin
                dens_next = dens_prod[DENS_SHIFT +: CDF_W];
                if (width_reg == '0)
                begin
                    // zero-width bin keeps the raw offset
                    state_next = ST_POS;
                end
                else if ({1'b0, off_reg} >= width_reg)
                begin
                    off_next   = POS_MAX;
                    state_next = ST_POS;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = {1'b0, off_reg};
                    div_req.divisor  = width_reg;
                    div_req.low_bits = '0;
                    state_next       = ST_ODIV;
                end
            end

            ST_ODIV:
            begin
                if (div_rsp.done)
                begin
                    off_next   = div_rsp.quotient;
                    state_next = ST_POS;
                end
            end

            ST_POS:
            begin
                // (idx * 2^F + off) / n, with idx < n the quotient stays below 1.0
                div_req.start    = 1'b1;
                div_req.rem_init = CDF_W'(lo_reg);
                div_req.divisor  = CDF_W'(n_reg);
                div_req.low_bits = off_reg;
                state_next       = ST_PDIV;
            end

            ST_PDIV:
            begin
                if (div_rsp.done)
                begin
                    pos_next   = div_rsp.quotient;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_pos_next   = pos_reg;
                    res_dens_next  = dens_reg;
                    res_idx_next   = lo_reg;
                    res_stat_next  = stat_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // size change discards the table
        if (cfg_accept)
        begin
            n_next     = size_clamped;
            lc_next    = '0;
            built_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= CNT_W'(MAX_BINS);
            lc_reg        <= '0;
            built_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            lc_reg        <= lc_next;
            built_reg     <= built_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg    <= total_next;
        bidx_reg     <= bidx_next;
        seed_reg     <= seed_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        lo_val_reg   <= lo_val_next;
        width_reg    <= width_next;
        off_reg      <= off_next;
        pos_reg      <= pos_next;
        dens_reg     <= dens_next;
        stat_reg     <= stat_next;
        res_pos_reg  <= res_pos_next;
        res_dens_reg <= res_dens_next;
        res_idx_reg  <= res_idx_next;
        res_stat_reg <= res_stat_next;
    end

    assign res_valid       = res_valid_reg;
    assign sample_position = res_pos_reg;
    assign density         = res_dens_reg;
    assign bin_index       = res_idx_reg;
    assign status          = res_stat_reg;

endmodule

`default_nettype wire

/* rtl/core/pcis_ram.sv */
// ----------------------------------------------------------------------------
// pcis_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcis_ram #(
    parameter int DATA_W = 25,
    parameter int DEPTH  = 257
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/pcis_div.sv */
// ----------------------------------------------------------------------------
// pcis_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcis_div
    import pcis_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CDF_W-1:0]         rem_reg, rem_next;
    logic [CDF_W-1:0]         den_reg, den_next;
    logic [FRACTION_BITS-1:0] low_reg, low_next;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;

    logic [CDF_W:0] trial;
    logic [CDF_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, low_reg[FRACTION_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits CDF_W bits
            rem_next = fits ? diff[CDF_W-1:0] : trial[CDF_W-1:0];
            low_next = {low_reg[FRACTION_BITS-2:0], 1'b0};
            quo_next = {quo_reg[FRACTION_BITS-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(FRACTION_BITS - 1);
            rem_next  = req.rem_init;
            den_next  = req.divisor;
            low_next  = req.low_bits;
            quo_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* verif/pcis_draw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcis_draw_checker
// Watches the cfg, req and res channels of the sampler, keeps its own copy of
// the CDF table, predicts every draw and compares results in order.
// ----------------------------------------------------------------------------
module pcis_draw_checker
    import pcis_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CNT_W-1:0]         size_in_use,
    input  logic                     req_valid,
    input  logic                     req_stall,
    input  logic                     op,
    input  logic [WEIGHT_BITS-1:0]   weight,
    input  logic [FRACTION_BITS-1:0] seed,
    input  logic                     res_valid,
    input  logic                     res_stall,
    input  logic [FRACTION_BITS-1:0] sample_position,
    input  logic [CDF_W-1:0]         density,
    input  logic [IDX_W-1:0]         bin_index,
    input  logic                     status,
    output int                       mismatches,
    output int                       pending,
    output int                       draws_checked,
    output int                       tables_built
);

    typedef struct packed {
        logic [FRACTION_BITS-1:0] position;
        logic [CDF_W-1:0]         density;
        logic [IDX_W-1:0]         bin;
        logic                     status;
    } draw_t;

    localparam longint unsigned ONE = 64'd1 << FRACTION_BITS;

    longint unsigned  cdf [RAM_DEPTH];   // prefix sums while loading, CDF after
    int unsigned      loaded;
    bit               built;
    logic [CNT_W-1:0] size_reg;
    draw_t            draws_due [$];

    function automatic int unsigned bins_in_use();
        if (size_reg == '0)
            return 1;
        if (size_reg > CNT_W'(MAX_BINS))
            return MAX_BINS;
        return int'(size_reg);
    endfunction

    // Normalize prefix sums; an all-zero table becomes a linear CDF.
    task automatic build_cdf(int unsigned n);
        longint unsigned total;
        total = cdf[n];
        cdf[0] = 0;
        for (int unsigned i = 1; i <= n; i++)
        begin
            if (total > 0)
                cdf[i] = (cdf[i] >= total) ? ONE : (cdf[i] << FRACTION_BITS) / total;
            else
                cdf[i] = (longint'(i) * ONE) / n;
        end
        cdf[n] = ONE;
        built = 1'b1;
        loaded = 0;
        tables_built++;
    endtask

    task automatic take_weight(logic [WEIGHT_BITS-1:0] w);
        int unsigned n;
        n = bins_in_use();
        if (built)
        begin
            built = 1'b0;
            loaded = 0;
        end
        if (loaded >= n)
            loaded = 0;
        if (loaded == 0)
            cdf[0] = 0;
        cdf[loaded + 1] = cdf[loaded] + w;
        loaded++;
        if (loaded >= n)
            build_cdf(n);
    endtask

    function automatic draw_t predict_draw(logic [FRACTION_BITS-1:0] s);
        draw_t           d;
        int unsigned     n;
        int unsigned     idx;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned span;
        longint unsigned offs;
        longint unsigned pos;
        longint unsigned dens;
        n = bins_in_use();
        d = '0;
        if (!built)
        begin
            d.status = STATUS_NOT_BUILT;
            return d;
        end
        idx = n - 1;
        while (idx > 0 && cdf[idx] > s)
            idx--;
        lo = cdf[idx];
        hi = cdf[idx + 1];
        span = (hi > lo) ? hi - lo : 0;
        offs = (s >= lo) ? s - lo : 0;
        // zero-width bin keeps the raw offset
        if (span > 0)
            offs = (offs >= span) ? ONE - 1 : (offs << FRACTION_BITS) / span;
        pos = (longint'(idx) * ONE + offs) / n;
        if (pos > ONE - 1)
            pos = ONE - 1;
        dens = ((span * n) << DENSITY_FRAC) >> FRACTION_BITS;
        d.position = pos[FRACTION_BITS-1:0];
        d.density  = dens[CDF_W-1:0];
        d.bin      = idx[IDX_W-1:0];
        d.status   = STATUS_OK;
        return d;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        draw_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < RAM_DEPTH; i++)
                cdf[i] = 0;
            loaded = 0;
            built = 1'b0;
            size_reg = CNT_W'(MAX_BINS);
            draws_due.delete();
            mismatches = 0;
            pending = 0;
            draws_checked = 0;
            tables_built = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (draws_due.size() == 0)
                begin
                    $display("%0t ns: result expected none, actual pos %0d dens %0d bin %0d st %0d",
                             $time, sample_position, density, bin_index, status);
                    mismatches++;
                end
                else
                begin
                    want = draws_due.pop_front();
                    check_field("sample_position", want.position, sample_position);
                    check_field("density", want.density, density);
                    check_field("bin_index", want.bin, bin_index);
                    check_field("status", want.status, status);
                    draws_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                size_reg = size_in_use;
                loaded = 0;
                built = 1'b0;
            end
            if (req_valid && !req_stall)
            begin
                if (op == OP_LOAD)
                    take_weight(weight);
                else
                    draws_due.push_back(predict_draw(seed));
            end
            pending = draws_due.size();
        end
    end

endmodule

/* verif/piecewise_constant_inverse_cdf_sampler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_constant_inverse_cdf_sampler_tb
// Drives weight loads, draws and size writes into the sampler with random
// gaps and result stalls; a separate checker predicts and compares each draw.
// ----------------------------------------------------------------------------
module piecewise_constant_inverse_cdf_sampler_tb;
    import pcis_pkg::*;

    localparam int     TOTAL_ITEMS = 1300;
    localparam int     MAX_GAP     = 6;
    // Cycle cap for the whole run; it leaves a wide margin over the slowest legal run.
    localparam longint CYCLE_LIMIT = 1_500_000;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         size_in_use = '0;
    logic                     req_valid   = 1'b0;
    logic                     req_stall;
    logic                     op          = OP_LOAD;
    logic [WEIGHT_BITS-1:0]   weight      = '0;
    logic [FRACTION_BITS-1:0] seed        = '0;
    logic                     res_valid;
    logic                     res_stall   = 1'b0;
    logic [FRACTION_BITS-1:0] sample_position;
    logic [CDF_W-1:0]         density;
    logic [IDX_W-1:0]         bin_index;
    logic                     status;

    int     mismatches;
    int     pending;
    int     draws_checked;
    int     tables_built;
    int     items_sent     = 0;
    int     settings_used  = 0;
    int     cur_bins       = MAX_BINS;   // effective bin count after clamping
    bit     loads_pending  = 1'b0;       // a build may still be running
    bit     quiet          = 1'b0;       // no gaps, no stalls in this stretch
    int     stall_left     = 0;
    longint cycle_count    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    piecewise_constant_inverse_cdf_sampler u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .size_in_use     (size_in_use),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .op              (op),
        .weight          (weight),
        .seed            (seed),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .sample_position (sample_position),
        .density         (density),
        .bin_index       (bin_index),
        .status          (status)
    );

    pcis_draw_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .size_in_use     (size_in_use),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .op              (op),
        .weight          (weight),
        .seed            (seed),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .sample_position (sample_position),
        .density         (density),
        .bin_index       (bin_index),
        .status          (status),
        .mismatches      (mismatches),
        .pending         (pending),
        .draws_checked   (draws_checked),
        .tables_built    (tables_built)
    );

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d draws outstanding", cycle_count, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Result side: for each result draw a random stall, counted only
    // while res_valid is up, so the stall lands on the result itself rather
    // than expiring while the block is still searching or dividing.
    always @(negedge clk)
    begin
        if (res_valid === 1'b1 && stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_stall <= 1'b0;
            if (res_valid === 1'b1)
                stall_left <= pick_gap();
        end
    end

    // Weights lean toward the corners: zero bins make zero-width CDF steps,
    // full-scale and tiny weights push the normalization extremes.
    function automatic logic [WEIGHT_BITS-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WEIGHT_BITS'($urandom_range(0, 15));
            default: return WEIGHT_BITS'($urandom);
        endcase
    endfunction

    // Seeds: both ends of the range, spots next to a linear-CDF boundary,
    // and plain uniform values.
    function automatic logic [FRACTION_BITS-1:0] rand_seed(int unsigned n);
        longint unsigned knee;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2:
            begin
                knee = (longint'($urandom_range(0, n)) << FRACTION_BITS) / n;
                knee = knee + $urandom_range(0, 2) - 1;
                return FRACTION_BITS'(knee);
            end
            default: return FRACTION_BITS'($urandom);
        endcase
    endfunction

    // One item on req. Called at a falling edge, returns at a falling edge
    // with req_valid still high; the next call either keeps it high (no gap)
    // or lowers it, so req_valid sees one assignment per time step.
    task automatic send_item(logic code, logic [WEIGHT_BITS-1:0] w,
                             logic [FRACTION_BITS-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        op <= code;
        weight <= w;
        seed <= s;
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
        end
        @(negedge clk);
        items_sent++;
        if (code == OP_LOAD)
            loads_pending = 1'b1;
    endtask

    task automatic load_weight(logic [WEIGHT_BITS-1:0] w);
        send_item(OP_LOAD, w, FRACTION_BITS'($urandom));
    endtask

    task automatic draw(logic [FRACTION_BITS-1:0] s);
        send_item(OP_SAMPLE, WEIGHT_BITS'($urandom), s);
    endtask

    // Sender holds off until the checker has seen every outstanding draw.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Size writes only go in while the block is idle. A load that finished
    // a table starts a build with no result to wait for, so give it the
    // worst-case build time first.
    task automatic write_size(logic [CNT_W-1:0] value);
        wait_drained();
        if (loads_pending)
            repeat (30 * cur_bins + 100) @(negedge clk);
        loads_pending = 1'b0;
        cfg_valid <= 1'b1;
        size_in_use <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (value == '0)
            cur_bins = 1;
        else if (value > CNT_W'(MAX_BINS))
            cur_bins = MAX_BINS;
        else
            cur_bins = int'(value);
        settings_used++;
    endtask

    initial
    begin : stimulus
        logic [CNT_W-1:0] setting;
        int               phase;
        int               rounds;
        int               kind;
        int               count;
        bit               zeroed;
        bit               hold_off;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // Draw right after reset: no table yet, so status flags it.
        draw(24'h123456);

        // Four bins with empty bins at 0 and 2 and a one-count bin at 3:
        // zero-width steps, index clamp and full-scale weight.
        write_size(CNT_W'(4));
        load_weight('0);
        load_weight('1);
        load_weight('0);
        load_weight(WEIGHT_BITS'(1));
        draw('0);
        draw('1);
        draw(24'h800000);
        draw(24'hFFFF00);
        wait_drained();

        // All-zero weights fall back to the linear CDF.
        repeat (4) load_weight('0);
        draw('0);
        draw('1);

        // Loading over a finished table throws it away; half a table
        // cannot serve draws.
        load_weight('1);
        load_weight('1);
        draw(24'h400000);

        // Completing that sequence gives an even table; probe a step edge.
        load_weight('1);
        load_weight('1);
        draw(24'h400000);
        draw(24'h3FFFFF);

        // ---- random part ----
        // First phases hit the size extremes: 0 (clamped up to 1), 1, the
        // 9-bit maximum (clamped to 256), 2 and exactly 256. After that most
        // phases use small tables so the run stays short.
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            case (phase)
                0: setting = '0;
                1: setting = CNT_W'(1);
                2: setting = '1;
                3: setting = CNT_W'(2);
                4: setting = CNT_W'(MAX_BINS);
                default:
                begin
                    if ($urandom_range(0, 5) == 0)
                        setting = CNT_W'($urandom_range(17, 40));
                    else
                        setting = CNT_W'($urandom_range(2, 16));
                end
            endcase
            write_size(setting);
            quiet = ($urandom_range(0, 3) == 0);
            rounds = (cur_bins > 64) ? 1 : $urandom_range(2, 4);

            repeat (rounds)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 8 && cur_bins > 1)
                begin
                    // broken sequence: part of a table, then draws on it
                    count = $urandom_range(1, cur_bins - 1);
                    repeat (count) load_weight(rand_weight());
                    repeat ($urandom_range(1, 2)) draw(rand_seed(cur_bins));
                end
                else if (kind == 9)
                begin
                    // draws on whatever the table currently is
                    repeat ($urandom_range(1, 4)) draw(rand_seed(cur_bins));
                end
                else
                begin
                    // well-formed: a full table, then a burst of draws
                    zeroed = ($urandom_range(0, 9) == 0);
                    repeat (cur_bins) load_weight(zeroed ? '0 : rand_weight());
                    count = (cur_bins > 64) ? 24 : $urandom_range(3, 12);
                    hold_off = ($urandom_range(0, 7) == 0);
                    for (int i = 0; i < count; i++)
                    begin
                        if (hold_off && i == count / 2)
                            wait_drained();
                        draw(rand_seed(cur_bins));
                    end
                end
            end
            phase++;
        end

        // Let the last draws come back and any final build settle.
        quiet = 1'b0;
        wait_drained();
        repeat (30 * cur_bins + 100) @(negedge clk);

        $display("Covered %0d items over %0d size settings, including clamped sizes,",
                 items_sent, settings_used);
        $display("zero-weight and partial tables; %0d draws checked, %0d tables built.",
                 draws_checked, tables_built);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
